/* hdl/plba_pkg.sv */
`default_nettype none
package plba_pkg;

	localparam int MaxLights = 128;
	localparam int BoostCap = 200;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [14:0]        radius;
		logic [7:0]         strength;
		logic [4:0]         chroma_red;
		logic [5:0]         chroma_green;
		logic [4:0]         chroma_blue;
	} in_item_t;

	typedef struct packed {
		logic [14:0] boost;
		logic [19:0] tint_red;
		logic [20:0] tint_green;
		logic [19:0] tint_blue;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIST,
		ST_DIV,
		ST_ACC,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture input item
		logic wr_light;  // write appended light
		logic clr_cnt;
		logic rd;        // unused; the tables read at the index on every clock
		logic sqdist;    // squared distance stage
		logic div_start;
		logic acc;       // accumulate one light
		logic clr_acc;
		logic show;      // unused; the result is presented with done
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       full;
		logic       last;      // index is the final stored light
		logic       empty;
		logic       hit;       // light reaches query point
		logic       div_done;
	} sts_t;

endpackage
`default_nettype wire

/* hdl/plba_ram.sv */
`default_nettype none
module plba_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/plba_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle: 38-bit dividend by 30-bit divisor
module plba_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [37:0] dividend,
	input  wire  [29:0] divisor,
	output logic        done,
	output logic [7:0]  quotient
);
	logic [37:0] quo_q;
	logic [30:0] rem_q;
	logic [29:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [31:0] trial;

	assign trial = {rem_q, quo_q[37]} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd38;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[31]) begin
				rem_q <= trial[30:0];
				quo_q <= {quo_q[36:0], 1'b1};
			end else begin
				rem_q <= {rem_q[29:0], quo_q[37]};
				quo_q <= {quo_q[36:0], 1'b0};
			end
		end
	end

	// quotient never exceeds the strength cap
	assign quotient = quo_q[7:0];
endmodule
`default_nettype wire

/* hdl/plba_datapath.sv */
`default_nettype none
module plba_datapath #(
	parameter int MaxLights = plba_pkg::MaxLights
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire plba_pkg::in_item_t in_item,
	input  wire plba_pkg::cmd_t  cmd,
	output plba_pkg::sts_t       sts,
	output plba_pkg::out_item_t  result
);
	localparam int AW = (MaxLights > 1) ? $clog2(MaxLights) : 1;
	localparam int CW = $clog2(MaxLights + 1);

	plba_pkg::in_item_t in_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [47:0]   pos_rd;
	logic [29:0]   r2_rd;
	logic [23:0]   sc_rd;
	logic [14:0]   rad;
	logic [7:0]    str;
	logic [29:0]   r2_wr;
	logic [33:0]   d2_q;
	logic [29:0]   r2_q;
	logic [23:0]   sc_q;
	logic [16:0]   dx, dy, dz;
	logic [33:0]   d2;
	logic [37:0]   num;
	logic [7:0]    b;
	logic          div_done;
	logic [22:0]   boost_q;
	logic [27:0]   tr_q, tb_q;
	logic [28:0]   tg_q;

	always_comb begin
		rad   = (in_item.radius == '0) ? 15'd1 : in_item.radius;
		str   = (in_item.strength > 8'(plba_pkg::BoostCap)) ? 8'(plba_pkg::BoostCap)
			: in_item.strength;
		r2_wr = {15'd0, rad} * {15'd0, rad};
	end

	plba_ram #(.Width(48), .Depth(1 << AW)) u_pos (
		.clk(clk), .we(cmd.wr_light), .waddr(count_q[AW-1:0]),
		.wdata({in_item.pos_x, in_item.pos_y, in_item.pos_z}),
		.raddr(idx_q), .rdata(pos_rd));
	plba_ram #(.Width(30), .Depth(1 << AW)) u_r2 (
		.clk(clk), .we(cmd.wr_light), .waddr(count_q[AW-1:0]),
		.wdata(r2_wr), .raddr(idx_q), .rdata(r2_rd));
	plba_ram #(.Width(24), .Depth(1 << AW)) u_sc (
		.clk(clk), .we(cmd.wr_light), .waddr(count_q[AW-1:0]),
		.wdata({str, in_item.chroma_red, in_item.chroma_green, in_item.chroma_blue}),
		.raddr(idx_q), .rdata(sc_rd));

	function automatic logic [16:0] absdiff(input logic signed [15:0] a,
		input logic signed [15:0] c);
		logic signed [16:0] d;
		begin
			d = 17'(a) - 17'(c);
			absdiff = d[16] ? 17'(-d) : d;
		end
	endfunction

	always_comb begin
		dx = absdiff(in_q.pos_x, pos_rd[47:32]);
		dy = absdiff(in_q.pos_y, pos_rd[31:16]);
		dz = absdiff(in_q.pos_z, pos_rd[15:0]);
		d2 = {17'd0, dx} * {17'd0, dx} + {17'd0, dy} * {17'd0, dy}
			+ {17'd0, dz} * {17'd0, dz};
	end

	// numerator for the divider, from the registered distance stage
	assign num = {30'd0, sc_q[23:16]} * {8'd0, r2_q - d2_q[29:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clr_cnt) begin
				count_q <= '0;
			end else if (cmd.wr_light) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.acc) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			in_q <= in_item;
		end
		if (cmd.sqdist) begin
			d2_q <= d2;
			r2_q <= r2_rd;
			sc_q <= sc_rd;
		end
		if (cmd.clr_acc) begin
			boost_q <= '0;
			tr_q    <= '0;
			tg_q    <= '0;
			tb_q    <= '0;
		end else if (cmd.acc && sts.hit) begin
			boost_q <= boost_q + 23'(b);
			tr_q    <= tr_q + {20'd0, b} * {23'd0, sc_q[15:11]};
			tg_q    <= tg_q + {21'd0, b} * {23'd0, sc_q[10:5]};
			tb_q    <= tb_q + {20'd0, b} * {23'd0, sc_q[4:0]};
		end
	end

	plba_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(num), .divisor(r2_q), .done(div_done), .quotient(b));

	always_comb begin
		sts.full     = (count_q == CW'(MaxLights));
		sts.last     = (CW'(idx_q) + CW'(1) >= count_q);
		sts.empty    = (count_q == '0);
		sts.hit      = (d2_q < 34'(r2_q));
		sts.div_done = div_done;
		result.boost      = (boost_q > 23'd32767) ? 15'h7fff : boost_q[14:0];
		result.tint_red   = (tr_q > 28'hfffff) ? 20'hfffff : tr_q[19:0];
		result.tint_green = (tg_q > 29'h1fffff) ? 21'h1fffff : tg_q[20:0];
		result.tint_blue  = (tb_q > 28'hfffff) ? 20'hfffff : tb_q[19:0];
	end
endmodule
`default_nettype wire

/* hdl/plba_ctrl.sv */
`default_nettype none
module plba_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire [1:0]           opcode,
	input  wire plba_pkg::sts_t sts,
	output logic                busy,
	output logic                done,
	output plba_pkg::cmd_t      cmd
);
	plba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != plba_pkg::ST_IDLE);
		done    = 1'b0;
		unique case (state_q)
			plba_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					unique case (opcode)
						plba_pkg::OP_CLEAR: cmd.clr_cnt = 1'b1;
						plba_pkg::OP_APPEND: cmd.wr_light = !sts.full;
						plba_pkg::OP_QUERY: begin
							cmd.clr_acc = 1'b1;
							state_d = plba_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			plba_pkg::ST_READ: begin
				// ram read of current index lands next cycle
				state_d = sts.empty ? plba_pkg::ST_DONE : plba_pkg::ST_DIST;
			end
			plba_pkg::ST_DIST: begin
				cmd.sqdist = 1'b1;
				state_d = plba_pkg::ST_DIV;
			end
			plba_pkg::ST_DIV: begin
				if (!sts.hit) begin
					state_d = plba_pkg::ST_ACC;
				end else begin
					cmd.div_start = 1'b1;
					state_d = plba_pkg::ST_ACC;
				end
			end
			plba_pkg::ST_ACC: begin
				// a reaching light waits here for the divider
				if (!sts.hit || sts.div_done) begin
					cmd.acc = 1'b1;
					state_d = sts.last ? plba_pkg::ST_DONE : plba_pkg::ST_READ;
				end
			end
			plba_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = plba_pkg::ST_IDLE;
			end
			default: state_d = plba_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* hdl/point_light_boost_accumulate_top.sv */
`default_nettype none
// clear and append: busy stays low, no result
// query: states read, distance, divide, accumulate per light, then done (an empty table
// goes read, done); a reaching light waits for the 38-step restoring divider
// result strobed by done for one cycle; the receiver cannot stall
// arst_n clears the light count and the controller; table contents stay undefined
module point_light_boost_accumulate_top #(
	parameter int MaxLights = plba_pkg::MaxLights
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire plba_pkg::in_item_t in_item,
	output logic                    busy,
	output logic                    done,
	output plba_pkg::out_item_t     result
);
	plba_pkg::cmd_t cmd;
	plba_pkg::sts_t sts;

	// controller: sequences the per-light walk
	plba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(in_item.opcode),
		.sts(sts), .busy(busy), .done(done), .cmd(cmd));

	// datapath: light tables, distance, divider and tint sums
	plba_datapath #(.MaxLights(MaxLights)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd),
		.sts(sts), .result(result));

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without query");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_light |-> !busy) else $error("append while busy");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
`endif
endmodule
`default_nettype wire

/* dv/point_light_boost_accumulate_top_tb.sv */
`timescale 1ns / 1ps
module point_light_boost_accumulate_top_tb;

	localparam int WatchdogLimit = 200000;

	logic clk;
	logic arst_n;
	logic start;
	plba_pkg::in_item_t in_item;
	logic busy;
	logic done;
	plba_pkg::out_item_t result;

	point_light_boost_accumulate_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_item(in_item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	// own copy of the light table
	int lamp_x[plba_pkg::MaxLights];
	int lamp_y[plba_pkg::MaxLights];
	int lamp_z[plba_pkg::MaxLights];
	longint lamp_r2[plba_pkg::MaxLights];
	int lamp_str[plba_pkg::MaxLights];
	int lamp_cr[plba_pkg::MaxLights];
	int lamp_cg[plba_pkg::MaxLights];
	int lamp_cb[plba_pkg::MaxLights];
	int lamp_count;

	plba_pkg::out_item_t tint_due[$];
	int mismatches;
	int idle_cycles;
	bit idling_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles without any transfer on either side
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WatchdogLimit) begin
			$display("point_light_boost_accumulate_top_tb: errors");
			$finish;
		end
	end

	// apply one accepted item to the light table and queue any expected sum
	function automatic void light_table_apply(input plba_pkg::in_item_t it);
		longint r, d2, dx, dy, dz, b, bs, tr, tg, tb;
		int s;
		plba_pkg::out_item_t o;
		case (plba_pkg::opcode_t'(it.opcode))
			plba_pkg::OP_CLEAR: lamp_count = 0;
			plba_pkg::OP_APPEND: begin
				if (lamp_count < plba_pkg::MaxLights) begin
					r = (it.radius == 0) ? 1 : it.radius;
					s = (it.strength > plba_pkg::BoostCap) ? plba_pkg::BoostCap
						: it.strength;
					lamp_x[lamp_count] = it.pos_x;
					lamp_y[lamp_count] = it.pos_y;
					lamp_z[lamp_count] = it.pos_z;
					lamp_r2[lamp_count] = r * r;
					lamp_str[lamp_count] = s;
					lamp_cr[lamp_count] = it.chroma_red;
					lamp_cg[lamp_count] = it.chroma_green;
					lamp_cb[lamp_count] = it.chroma_blue;
					lamp_count++;
				end
			end
			plba_pkg::OP_QUERY: begin
				bs = 0; tr = 0; tg = 0; tb = 0;
				for (int i = 0; i < lamp_count; i++) begin
					dx = longint'(it.pos_x) - lamp_x[i];
					dy = longint'(it.pos_y) - lamp_y[i];
					dz = longint'(it.pos_z) - lamp_z[i];
					d2 = dx * dx + dy * dy + dz * dz;
					if (d2 < lamp_r2[i]) begin
						b = (lamp_str[i] * (lamp_r2[i] - d2)) / lamp_r2[i];
						bs += b;
						tr += b * lamp_cr[i];
						tg += b * lamp_cg[i];
						tb += b * lamp_cb[i];
					end
				end
				// saturate at field maxima
				o.boost = (bs > 32767) ? 15'h7fff : bs[14:0];
				o.tint_red = (tr > 1048575) ? 20'hfffff : tr[19:0];
				o.tint_green = (tg > 2097151) ? 21'h1fffff : tg[20:0];
				o.tint_blue = (tb > 1048575) ? 20'hfffff : tb[19:0];
				tint_due.push_back(o);
			end
			default: ;
		endcase
	endfunction

	// result checker, field by field against the oldest expectation
	always @(posedge clk) begin
		plba_pkg::out_item_t want;
		if (arst_n && done) begin
			if (tint_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = tint_due.pop_front();
				if (result.boost !== want.boost || result.tint_red !== want.tint_red
						|| result.tint_green !== want.tint_green
						|| result.tint_blue !== want.tint_blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected b=%0d r=%0d g=%0d bl=%0d,",
							want.boost, want.tint_red, want.tint_green, want.tint_blue,
							" got b=%0d r=%0d g=%0d bl=%0d",
							result.boost, result.tint_red, result.tint_green,
							result.tint_blue);
				end
			end
		end
	end

	// send one item: random gap when idling is on, then hold start until the transfer
	task automatic send_item(input plba_pkg::in_item_t it);
		int gap;
		if (idling_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		light_table_apply(it);
	endtask

	task automatic release_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic plba_pkg::in_item_t any_item(input plba_pkg::opcode_t op);
		plba_pkg::in_item_t it;
		it = plba_pkg::in_item_t'($bits(plba_pkg::in_item_t)'(
			{$urandom, $urandom, $urandom, $urandom}));
		it.opcode = op;
		return it;
	endfunction

	// light near a center so queries land inside its reach
	function automatic plba_pkg::in_item_t near_light(input int cx, input int cy,
		input int cz);
		plba_pkg::in_item_t it;
		it = any_item(plba_pkg::OP_APPEND);
		it.pos_x = 16'(cx + $urandom_range(0, 200) - 100);
		it.pos_y = 16'(cy + $urandom_range(0, 200) - 100);
		it.pos_z = 16'(cz + $urandom_range(0, 200) - 100);
		it.radius = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 400));
		it.strength = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 200));
		return it;
	endfunction

	function automatic plba_pkg::in_item_t near_query(input int cx, input int cy,
		input int cz);
		plba_pkg::in_item_t it;
		it = any_item(plba_pkg::OP_QUERY);
		it.pos_x = 16'(cx + $urandom_range(0, 300) - 150);
		it.pos_y = 16'(cy + $urandom_range(0, 300) - 150);
		it.pos_z = 16'(cz + $urandom_range(0, 300) - 150);
		return it;
	endfunction

	// extremes, every opcode, empty table, clamps
	task automatic test_directed();
		plba_pkg::in_item_t it;
		send_item(any_item(plba_pkg::OP_QUERY));     // empty table gives zeros
		send_item(any_item(plba_pkg::OP_NONE));      // unused opcode, no result
		it = '0; it.opcode = plba_pkg::OP_APPEND;    // radius 0 taken as 1
		it.strength = 8'hff; it.chroma_red = 5'h1f;  // strength above cap
		it.chroma_green = 6'h3f; it.chroma_blue = 5'h1f;
		send_item(it);
		it.opcode = plba_pkg::OP_QUERY;
		send_item(it);                               // at the center
		it = '0; it.opcode = plba_pkg::OP_APPEND;
		it.pos_x = 16'sh7fff; it.pos_y = -16'sh8000; it.pos_z = 16'sh7fff;
		it.radius = 15'h7fff; it.strength = 8'd200;
		it.chroma_red = 5'h15; it.chroma_green = 6'h2a; it.chroma_blue = 5'h0a;
		send_item(it);
		it.opcode = plba_pkg::OP_QUERY;
		send_item(it);
		it.pos_x = -16'sh8000; it.pos_y = 16'sh7fff; it.pos_z = -16'sh8000;
		send_item(it);                               // farthest corner
		it.pos_x = 16'sh7fff - 16'sd100; it.pos_y = -16'sh8000; it.pos_z = 16'sh7fff;
		send_item(it);
		send_item(any_item(plba_pkg::OP_CLEAR));
		send_item(any_item(plba_pkg::OP_QUERY));
		// fill the table past capacity at the same spot
		for (int i = 0; i < plba_pkg::MaxLights + 3; i++)
			send_item(near_light(0, 0, 0));
		send_item(near_query(0, 0, 0));
		it = '0; it.opcode = plba_pkg::OP_QUERY;
		send_item(it);
		send_item(any_item(plba_pkg::OP_CLEAR));
		release_start();
	endtask

	// mostly clustered lights with queries among them, some noise
	task automatic test_random(input int n_items);
		int cx, cy, cz, pick;
		cx = 0; cy = 0; cz = 0;
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_item(any_item(plba_pkg::OP_CLEAR));
				cx = $signed(16'($urandom)) / 2;
				cy = $signed(16'($urandom)) / 2;
				cz = $signed(16'($urandom)) / 2;
			end else if (pick < 5) begin
				send_item(any_item(plba_pkg::OP_NONE));
			end else if (pick < 45) begin
				send_item(near_light(cx, cy, cz));
			end else if (pick < 50) begin
				send_item(any_item(plba_pkg::OP_APPEND));
			end else if (pick < 95) begin
				send_item(near_query(cx, cy, cz));
			end else begin
				send_item(any_item(plba_pkg::OP_QUERY));
			end
		end
		release_start();
	endtask

	// hold off the sender until all pending results are in
	task automatic test_drain_pause();
		while (tint_due.size() != 0) @(posedge clk);
		send_item(near_query(0, 0, 0));
		release_start();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		lamp_count = 0;
		idling_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(450);
		test_drain_pause();
		test_random(300);
		idling_on = 1'b0;   // back-to-back for the last part
		test_random(150);
		while (tint_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("point_light_boost_accumulate_top_tb: clean");
		end else begin
			$display("point_light_boost_accumulate_top_tb: errors");
		end
		$finish;
	end

endmodule
